/* src/ipru_pkg.sv */
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types, constants and helpers for the integer pixel replication
// upscaler: field widths, command and kind codes, register indexes and the
// beat-group descriptor passed from the control stage to the output stage.
// ----------------------------------------------------------------------------
package ipru_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_SCALE  = 16;

    localparam int PIX_W   = 24;
    localparam int WIDTH_W = 12;                      // source_width register
    localparam int HEIGHT_W = 12;                     // source_height register
    localparam int SCALE_W = 5;                       // scale_factor register
    localparam int CFG_W   = 12;                      // widest register
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);       // line store address
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int REP_W   = $clog2(MAX_SCALE);
    localparam int BEAT_W  = 5;                       // up to scale plus three pad beats

    // Command codes carried on the input tuser.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_PAD   = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

    // One group of result beats caused by one accepted input beat.
    typedef struct packed {
        logic              drop;        // single dropped-input beat
        logic              from_ram;    // pixel comes from the line store read
        logic [PIX_W-1:0]  pixel;
        logic [BEAT_W-1:0] copies;      // horizontal copies, 1..16
        logic [1:0]        pad;         // zero padding beats at row end
        logic              row_done;
        logic              frame_done;
    } desc_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (v == '0) begin
            r = WIDTH_W'(1);
        end else if (v > WIDTH_W'(MAX_WIDTH)) begin
            r = WIDTH_W'(MAX_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (v == '0) begin
            r = HEIGHT_W'(1);
        end else if (v > HEIGHT_W'(MAX_HEIGHT)) begin
            r = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
        logic [SCALE_W-1:0] r;
        if (v == '0) begin
            r = SCALE_W'(1);
        end else if (v > SCALE_W'(MAX_SCALE)) begin
            r = SCALE_W'(MAX_SCALE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* src/integer_pixel_replication_upscaler.sv */
// An accepted item passes the descriptor register in the control stage and the job
// register in the output stage before its first result beat is offered.
// Throughput: one result beat per cycle while m_tready is high; an item holds the
// output for scale beats, plus up to three padding beats at row end, or one beat
// for a dropped pixel. A tick with nothing to replay is accepted and gives no beat.
// Reset: synchronous active-low aresetn clears counters and registers (width, height
// and scale return to one); the line store is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbour integer upscaler for 24-bit pixels: each source pixel is
// repeated horizontally, rows are padded to four bytes, and the row held in
// the line store is replayed scale minus one more times on tick beats.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipru_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [23:0] pixel_in
    input  logic [0:0]                     s_tuser,   // [0] command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [23:0] pixel_out, [24] row_end,
                                                      // [25] frame_end, [31:26] zero
    output logic [1:0]                     m_tuser,   // [1:0] kind
    output logic                           m_tlast    // last
);

    logic                          ram_wr_en;
    logic [ipru_pkg::ADDR_W-1:0]   ram_wr_addr;
    logic                          ram_rd_en;
    logic [ipru_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [ipru_pkg::PIX_W-1:0]    ram_rd_data;
    logic                          desc_valid;
    ipru_pkg::desc_t               desc;
    logic                          desc_take;
    logic [ipru_pkg::PIX_W-1:0]    m_pixel;
    logic                          m_row_end;
    logic                          m_frame_end;

    ipru_ram #(
        .WIDTH(ipru_pkg::PIX_W),
        .DEPTH(ipru_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ipru_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_pixel     (s_tdata),
        .s_command   (s_tuser[0]),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .desc_take   (desc_take)
    );

    ipru_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .desc_take   (desc_take),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_kind      (m_tuser),
        .m_pixel     (m_pixel),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .m_last      (m_tlast)
    );

    assign m_tdata = {6'd0, m_frame_end, m_row_end, m_pixel};

endmodule

/* src/ipru_ram.sv */
// ----------------------------------------------------------------------------
// ipru_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module ipru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/ipru_ctrl.sv */
// ----------------------------------------------------------------------------
// ipru_ctrl
// Input stage: holds the configuration registers and the row and replay
// counters, writes pushed pixels into the line store, issues line store reads
// for replay ticks and hands one descriptor per result group to the output
// stage.
// ----------------------------------------------------------------------------
module ipru_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [ipru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipru_pkg::CFG_W-1:0]     cfg_wdata,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ipru_pkg::PIX_W-1:0]     s_pixel,
    input  logic                          s_command,
    // line store
    output logic                          ram_wr_en,
    output logic [ipru_pkg::ADDR_W-1:0]    ram_wr_addr,
    output logic                          ram_rd_en,
    output logic [ipru_pkg::ADDR_W-1:0]    ram_rd_addr,
    // descriptor to output stage
    output logic                          desc_valid,
    output ipru_pkg::desc_t               desc,
    input  logic                          desc_take
);

    logic [ipru_pkg::WIDTH_W-1:0]  width_cfg_reg;
    logic [ipru_pkg::HEIGHT_W-1:0] height_cfg_reg;
    logic [ipru_pkg::SCALE_W-1:0]  scale_cfg_reg;

    logic [ipru_pkg::ADDR_W-1:0] column_reg, column_next;
    logic [ipru_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ipru_pkg::REP_W-1:0]  repeats_reg, repeats_next;
    logic                        replay_reg, replay_next;
    logic [ipru_pkg::ADDR_W-1:0] replay_col_reg, replay_col_next;

    logic             desc_valid_reg, desc_valid_next;
    ipru_pkg::desc_t  desc_reg, desc_next;

    logic [ipru_pkg::WIDTH_W-1:0]  w_eff;
    logic [ipru_pkg::HEIGHT_W-1:0] h_eff;
    logic [ipru_pkg::SCALE_W-1:0]  s_eff;
    logic [1:0]                    pad_eff;
    logic [3:0]                    pad_prod;
    logic                          accept;
    logic                          push_row_done;
    logic                          tick_row_done;
    logic                          row_wrap;
    logic [ipru_pkg::HEIGHT_W-1:0] row_inc;
    logic [ipru_pkg::REP_W-1:0]    repeats_dec;

    assign w_eff = ipru_pkg::clamp_width(width_cfg_reg);
    assign h_eff = ipru_pkg::clamp_height(height_cfg_reg);
    assign s_eff = ipru_pkg::clamp_scale(scale_cfg_reg);

    // 3*w*s padded to a multiple of four needs (w*s) mod 4 zero bytes.
    assign pad_prod = w_eff[1:0] * s_eff[1:0];
    assign pad_eff  = pad_prod[1:0];

    assign s_tready = !desc_valid_reg || desc_take;
    assign accept   = s_tvalid && s_tready;

    assign push_row_done = ({1'b0, column_reg} + ipru_pkg::WIDTH_W'(1)) >= w_eff;
    assign tick_row_done = ({1'b0, replay_col_reg} + ipru_pkg::WIDTH_W'(1)) >= w_eff;
    assign row_inc       = {1'b0, row_reg} + ipru_pkg::HEIGHT_W'(1);
    assign row_wrap      = row_inc >= h_eff;
    assign repeats_dec   = (repeats_reg != '0) ? repeats_reg - ipru_pkg::REP_W'(1)
                                               : repeats_reg;

    // A tick reads the line store at a later edge than the push that wrote
    // the entry, so the registered read never needs forwarding.
    assign ram_wr_en   = accept && (s_command == ipru_pkg::CMD_PUSH) && !replay_reg;
    assign ram_wr_addr = column_reg;
    assign ram_rd_en   = accept && (s_command == ipru_pkg::CMD_TICK) && replay_reg;
    assign ram_rd_addr = replay_col_reg;

    always_comb begin
        column_next     = column_reg;
        row_next        = row_reg;
        repeats_next    = repeats_reg;
        replay_next     = replay_reg;
        replay_col_next = replay_col_reg;
        desc_valid_next = desc_valid_reg && !desc_take;
        desc_next       = desc_reg;

        if (accept) begin
            desc_next.drop       = 1'b0;
            desc_next.from_ram   = 1'b0;
            desc_next.pixel      = s_pixel;
            desc_next.copies     = s_eff;
            desc_next.pad        = 2'd0;
            desc_next.row_done   = 1'b0;
            desc_next.frame_done = 1'b0;

            if (s_command == ipru_pkg::CMD_PUSH) begin
                desc_valid_next = 1'b1;
                if (replay_reg) begin
                    desc_next.drop   = 1'b1;
                    desc_next.copies = ipru_pkg::BEAT_W'(1);
                end else if (push_row_done) begin
                    desc_next.row_done = 1'b1;
                    desc_next.pad      = pad_eff;
                    column_next        = '0;
                    if (s_eff > ipru_pkg::SCALE_W'(1)) begin
                        replay_next     = 1'b1;
                        repeats_next    = ipru_pkg::REP_W'(s_eff - ipru_pkg::SCALE_W'(1));
                        replay_col_next = '0;
                    end else begin
                        desc_next.frame_done = row_wrap;
                        row_next = row_wrap ? '0 : row_inc[ipru_pkg::ROW_W-1:0];
                    end
                end else begin
                    column_next = column_reg + ipru_pkg::ADDR_W'(1);
                end
            end else if (replay_reg) begin
                desc_valid_next    = 1'b1;
                desc_next.from_ram = 1'b1;
                if (tick_row_done) begin
                    desc_next.row_done = 1'b1;
                    desc_next.pad      = pad_eff;
                    replay_col_next    = '0;
                    repeats_next       = repeats_dec;
                    if (repeats_dec == '0) begin
                        replay_next          = 1'b0;
                        desc_next.frame_done = row_wrap;
                        row_next = row_wrap ? '0 : row_inc[ipru_pkg::ROW_W-1:0];
                    end
                end else begin
                    replay_col_next = replay_col_reg + ipru_pkg::ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= ipru_pkg::WIDTH_W'(1);
            height_cfg_reg <= ipru_pkg::HEIGHT_W'(1);
            scale_cfg_reg  <= ipru_pkg::SCALE_W'(1);
            column_reg     <= '0;
            row_reg        <= '0;
            repeats_reg    <= '0;
            replay_reg     <= 1'b0;
            replay_col_reg <= '0;
            desc_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ipru_pkg::REG_SOURCE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    ipru_pkg::REG_SOURCE_HEIGHT: height_cfg_reg <= cfg_wdata;
                    ipru_pkg::REG_SCALE_FACTOR:  scale_cfg_reg  <= cfg_wdata[ipru_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            column_reg     <= column_next;
            row_reg        <= row_next;
            repeats_reg    <= repeats_next;
            replay_reg     <= replay_next;
            replay_col_reg <= replay_col_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

    // Replay only ever runs with at least one repeat outstanding.
    a_replay_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        replay_reg |-> (repeats_reg != '0))
        else $error("replay active with no repeats left");

    // Pushes during replay are dropped, not written, so the push column stays at zero.
    a_replay_column: assert property (@(posedge aclk) disable iff (!aresetn)
        replay_reg |-> (column_reg == '0))
        else $error("push column moved during replay");

    // A waiting descriptor is not overwritten.
    a_desc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (desc_valid_reg && !desc_take) |=> (desc_valid_reg && $stable(desc_reg)))
        else $error("pending descriptor lost");

endmodule

/* src/ipru_emit.sv */
// ----------------------------------------------------------------------------
// ipru_emit
// Output stage: expands one descriptor into its result beats (copies, then zero
// padding at row end, or one dropped-input beat) one beat a cycle while ready.
// ----------------------------------------------------------------------------
module ipru_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       desc_valid,
    input  ipru_pkg::desc_t            desc,
    output logic                       desc_take,
    input  logic [ipru_pkg::PIX_W-1:0]  ram_rd_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [1:0]                 m_kind,
    output logic [ipru_pkg::PIX_W-1:0]  m_pixel,
    output logic                       m_row_end,
    output logic                       m_frame_end,
    output logic                       m_last
);

    logic                        job_valid_reg, job_valid_next;
    ipru_pkg::desc_t             job_reg, job_next;
    logic [ipru_pkg::PIX_W-1:0]  pix_reg, pix_next;
    logic [ipru_pkg::BEAT_W-1:0] idx_reg, idx_next;

    logic [ipru_pkg::BEAT_W-1:0] total;
    logic                        in_copies;
    logic                        fin;
    logic                        beat_done;

    assign total     = job_reg.copies + ipru_pkg::BEAT_W'(job_reg.pad);
    assign in_copies = idx_reg < job_reg.copies;
    assign fin       = (idx_reg + ipru_pkg::BEAT_W'(1)) == total;
    assign beat_done = job_valid_reg && m_tready;

    // The line store read data is still held when its descriptor is taken,
    // because no new read is issued while the descriptor waits.
    assign desc_take = desc_valid && (!job_valid_reg || (beat_done && fin));

    always_comb begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        if (desc_take) begin
            job_valid_next = 1'b1;
            job_next       = desc;
            pix_next       = desc.from_ram ? ram_rd_data : desc.pixel;
            idx_next       = '0;
        end else if (beat_done) begin
            if (fin) begin
                job_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + ipru_pkg::BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        pix_reg <= pix_next;
    end

    always_comb begin
        if (job_reg.drop) begin
            m_kind = ipru_pkg::KIND_DROP;
        end else if (in_copies) begin
            m_kind = ipru_pkg::KIND_PIXEL;
        end else begin
            m_kind = ipru_pkg::KIND_PAD;
        end
    end

    assign m_tvalid    = job_valid_reg;
    assign m_pixel     = (job_reg.drop || in_copies) ? pix_reg : '0;
    assign m_row_end   = !job_reg.drop && job_reg.row_done && fin;
    assign m_frame_end = m_row_end && job_reg.frame_done;
    assign m_last      = fin;

    // The beat index never runs past the end of its group.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (idx_reg < total))
        else $error("beat index beyond group length");

    // A stalled beat keeps its position in the group.
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !m_tready) |=> (job_valid_reg && $stable(idx_reg)))
        else $error("beat position moved while stalled");

    // A frame end is always also a row end and the last beat of its group.
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && m_frame_end) |-> (m_row_end && m_last))
        else $error("frame end without row end");

endmodule

/* sim/integer_pixel_replication_upscaler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_tb
// Self-checking bench for the pixel replication upscaler. A behavioural copy
// of the upscaler predicts every result beat from the accepted input beats,
// and a checker compares each output beat with the oldest prediction. Both
// stream sides idle at random while configuration changes between phases.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler_tb;

    localparam int RANDOM_ITEMS = 90;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [ipru_pkg::PIX_W-1:0] pixel;
        logic                       row_end;
        logic                       frame_end;
        logic                       last;
    } out_beat_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ipru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ipru_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata = '0;
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [31:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;

    integer_pixel_replication_upscaler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the configuration and the upscaler state.
    logic [ipru_pkg::WIDTH_W-1:0]  width_reg = ipru_pkg::WIDTH_W'(1);
    logic [ipru_pkg::HEIGHT_W-1:0] height_reg = ipru_pkg::HEIGHT_W'(1);
    logic [ipru_pkg::SCALE_W-1:0]  scale_reg = ipru_pkg::SCALE_W'(1);
    logic [ipru_pkg::PIX_W-1:0]    line_mem [ipru_pkg::MAX_WIDTH];
    logic [ipru_pkg::ADDR_W-1:0]   col_cnt = '0;
    logic [ipru_pkg::ROW_W:0]      row_cnt = '0;
    logic [ipru_pkg::REP_W-1:0]    reps_left = '0;
    logic                          replaying = 1'b0;
    logic [ipru_pkg::ADDR_W-1:0]   replay_col = '0;
    int                            filled_cols = 0;

    out_beat_t pending_beats[$];
    out_beat_t head_beat;

    int  error_count = 0;
    int  beats_checked = 0;
    int  drops_seen = 0;
    int  frames_seen = 0;
    int  live_items = 0;
    int  ignored_ticks = 0;
    bit  no_idle = 1'b0;
    int  rx_hold = 0;

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int cur_width();
        return clamp_to(int'(width_reg), ipru_pkg::MAX_WIDTH);
    endfunction

    function automatic int cur_scale();
        return clamp_to(int'(scale_reg), ipru_pkg::MAX_SCALE);
    endfunction

    // One output row group is done; true when it closes the frame.
    function automatic bit close_row_group();
        row_cnt++;
        if (int'(row_cnt) >= clamp_to(int'(height_reg), ipru_pkg::MAX_HEIGHT)) begin
            row_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Horizontal copies of one pixel, with zero padding bytes at row end.
    task automatic queue_copies(input logic [ipru_pkg::PIX_W-1:0] pix, input bit row_done,
                                input bit frame_done);
        int s;
        int pad;
        int total;
        out_beat_t b;
        s = cur_scale();
        pad = row_done ? (4 - ((3 * cur_width() * s) % 4)) % 4 : 0;
        total = s + pad;
        for (int i = 0; i < total; i++) begin
            b.kind      = (i < s) ? ipru_pkg::KIND_PIXEL : ipru_pkg::KIND_PAD;
            b.pixel     = (i < s) ? pix : '0;
            b.row_end   = row_done && (i + 1 == total);
            b.frame_end = b.row_end && frame_done;
            b.last      = (i + 1 == total);
            pending_beats.push_back(b);
        end
    endtask

    task automatic upscale_item(input logic cmd, input logic [ipru_pkg::PIX_W-1:0] pix);
        int w;
        bit row_done;
        bit frame_done;
        out_beat_t b;
        w = cur_width();
        frame_done = 1'b0;
        if (cmd == ipru_pkg::CMD_PUSH) begin
            if (replaying) begin
                b.kind      = ipru_pkg::KIND_DROP;
                b.pixel     = pix;
                b.row_end   = 1'b0;
                b.frame_end = 1'b0;
                b.last      = 1'b1;
                pending_beats.push_back(b);
            end else begin
                row_done = int'(col_cnt) + 1 >= w;
                line_mem[col_cnt] = pix;
                if (int'(col_cnt) + 1 > filled_cols) filled_cols = int'(col_cnt) + 1;
                if (row_done) begin
                    col_cnt = '0;
                    if (cur_scale() > 1) begin
                        replaying  = 1'b1;
                        reps_left  = ipru_pkg::REP_W'(cur_scale() - 1);
                        replay_col = '0;
                    end else begin
                        frame_done = close_row_group();
                    end
                end else begin
                    col_cnt++;
                end
                queue_copies(pix, row_done, frame_done);
            end
        end else if (replaying) begin
            row_done = int'(replay_col) + 1 >= w;
            b.pixel = line_mem[replay_col];
            if (row_done) begin
                replay_col = '0;
                if (reps_left > 0) reps_left--;
                if (reps_left == 0) begin
                    replaying  = 1'b0;
                    frame_done = close_row_group();
                end
            end else begin
                replay_col++;
            end
            queue_copies(b.pixel, row_done, frame_done);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                 $realtime, what, want, got);
    endtask

    // Result checker: every accepted output beat against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat, kind", 0, m_tuser);
            end else begin
                head_beat = pending_beats.pop_front();
                if (m_tuser != head_beat.kind)
                    report_mismatch("kind", head_beat.kind, m_tuser);
                if (m_tdata[23:0] != head_beat.pixel)
                    report_mismatch("pixel_out", head_beat.pixel, m_tdata[23:0]);
                if (m_tdata[24] != head_beat.row_end)
                    report_mismatch("row_end", head_beat.row_end, m_tdata[24]);
                if (m_tdata[25] != head_beat.frame_end)
                    report_mismatch("frame_end", head_beat.frame_end, m_tdata[25]);
                if (m_tlast != head_beat.last)
                    report_mismatch("last", head_beat.last, m_tlast);
                if (head_beat.kind == ipru_pkg::KIND_DROP) drops_seen++;
                if (head_beat.frame_end) frames_seen++;
            end
        end
    end

    // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (no_idle || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
        end
    end

    function automatic int sender_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic cmd, input logic [ipru_pkg::PIX_W-1:0] pix);
        int gap;
        int queued;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        queued = pending_beats.size();
        upscale_item(cmd, pix);
        if (pending_beats.size() == queued) ignored_ticks++;
        else live_items++;
    endtask

    // Hold the sender until every predicted beat has come out, then let the
    // pipeline settle in case a result-free tick is still in flight.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ipru_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= ipru_pkg::CFG_W'(value);
        case (idx)
            ipru_pkg::REG_SOURCE_WIDTH:  width_reg = ipru_pkg::WIDTH_W'(value);
            ipru_pkg::REG_SOURCE_HEIGHT: height_reg = ipru_pkg::HEIGHT_W'(value);
            ipru_pkg::REG_SCALE_FACTOR:  scale_reg = ipru_pkg::SCALE_W'(value);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int s);
        wait_drained();
        write_reg(ipru_pkg::REG_SOURCE_WIDTH, w);
        write_reg(ipru_pkg::REG_SOURCE_HEIGHT, h);
        write_reg(ipru_pkg::REG_SCALE_FACTOR, s);
    endtask

    // Push the rest of the current row, then tick out every replay.
    task automatic complete_row();
        if (!replaying) begin
            do send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom)); while (col_cnt != 0);
        end
        while (replaying) send_item(ipru_pkg::CMD_TICK, ipru_pkg::PIX_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        no_idle = 1'b1;
        send_item(ipru_pkg::CMD_PUSH, 24'h000000);
        send_item(ipru_pkg::CMD_PUSH, 24'hFFFFFF);
        send_item(ipru_pkg::CMD_TICK, 24'hFFFFFF);
        no_idle = 1'b0;
    endtask

    task automatic test_replay_and_drops();
        // A one-pixel row at scale three needs three padding bytes per row.
        set_geometry(1, 0, 3);
        send_item(ipru_pkg::CMD_PUSH, 24'hA5A5A5);
        send_item(ipru_pkg::CMD_PUSH, 24'h5A5A5A);
        send_item(ipru_pkg::CMD_TICK, 24'h000000);
        send_item(ipru_pkg::CMD_TICK, 24'hFFFFFF);
        send_item(ipru_pkg::CMD_TICK, 24'h123456);
    endtask

    task automatic test_scale_clamp();
        set_geometry(1, 1, 31);
        complete_row();
        set_geometry(0, 0, 0);
        send_item(ipru_pkg::CMD_PUSH, 24'hC3C3C3);
    endtask

    task automatic test_mid_row_changes();
        set_geometry(4095, 4095, 2);
        repeat (3) send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
        // Narrowing below the current column ends the row on the next pixel.
        wait_drained();
        write_reg(ipru_pkg::REG_SOURCE_WIDTH, 2);
        send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
        // A new scale changes the copies but not the remaining repeat count.
        wait_drained();
        write_reg(ipru_pkg::REG_SCALE_FACTOR, 5);
        complete_row();
        set_geometry(2, 4095, 3);
        complete_row();
        repeat (2) send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
        send_item(ipru_pkg::CMD_TICK, ipru_pkg::PIX_W'($urandom));
        wait_drained();
        write_reg(ipru_pkg::REG_SOURCE_WIDTH, 1);
        complete_row();
        set_geometry(0, 0, 0);
        send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
    endtask

    // Widths at or above the line store depth leave a short row open; narrowing
    // then closes it on the next pixel.
    task automatic test_widest_row();
        set_geometry(4095, 1, 1);
        repeat (6) send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
        wait_drained();
        write_reg(ipru_pkg::REG_SOURCE_WIDTH, 2);
        complete_row();
        set_geometry(2048, 2, 1);
        repeat (6) send_item(ipru_pkg::CMD_PUSH, ipru_pkg::PIX_W'($urandom));
        wait_drained();
        write_reg(ipru_pkg::REG_SOURCE_WIDTH, 5);
        complete_row();
    endtask

    task automatic test_random_traffic();
        int goal;
        int n;
        int w;
        goal = live_items + RANDOM_ITEMS;
        while (live_items < goal) begin
            wait_drained();
            if ($urandom_range(0, 1) == 1) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 6);
                // Never let a replay reach line store entries not yet written.
                if (replaying && clamp_to(w, ipru_pkg::MAX_WIDTH) > filled_cols)
                    w = filled_cols;
                write_reg(ipru_pkg::REG_SOURCE_WIDTH, w);
            end
            if ($urandom_range(0, 1) == 1)
                write_reg(ipru_pkg::REG_SOURCE_HEIGHT, $urandom_range(0, 4));
            if ($urandom_range(0, 1) == 1)
                write_reg(ipru_pkg::REG_SCALE_FACTOR, ($urandom_range(0, 9) == 0)
                                                      ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 5));
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 3 * cur_width() * cur_scale() + 2);
            if (n > 24) n = 24;
            // Mostly the command the current state wants, sometimes the other.
            repeat (n) begin
                if ($urandom_range(0, 99) < 88)
                    send_item(replaying ? ipru_pkg::CMD_TICK : ipru_pkg::CMD_PUSH,
                              ipru_pkg::PIX_W'($urandom));
                else
                    send_item(replaying ? ipru_pkg::CMD_PUSH : ipru_pkg::CMD_TICK,
                              ipru_pkg::PIX_W'($urandom));
            end
        end
        no_idle = 1'b0;
        complete_row();
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_replay_and_drops();
        test_scale_clamp();
        test_mid_row_changes();
        test_widest_row();
        test_random_traffic();
        wait_drained();
        $display("Run covered %0d input beats with results and %0d idle ticks,",
                 live_items, ignored_ticks);
        $display("%0d result beats checked, %0d dropped pixels and %0d frame ends.",
                 beats_checked, drops_seen, frames_seen);
        if (error_count == 0 && pending_beats.size() == 0) begin
            $display("integer_pixel_replication_upscaler verification clean");
        end else begin
            $display("integer_pixel_replication_upscaler verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d beats still expected.", pending_beats.size());
        $display("integer_pixel_replication_upscaler verification failed");
        $finish;
    end

endmodule

/* files.f */
src/ipru_pkg.sv
src/ipru_ram.sv
src/ipru_ctrl.sv
src/ipru_emit.sv
src/integer_pixel_replication_upscaler.sv
sim/integer_pixel_replication_upscaler_tb.sv
